// File: hw/rtl/pdsd_pkg.sv
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared constants for the point to stroke distance pipeline.
// ----------------------------------------------------------------------------
package pdsd_pkg;

  // extra fraction bits carried by the line length
  localparam int unsigned LEN_EXTRA = 16;

endpackage

// File: hw/rtl/pdsd_in_if.sv
// ----------------------------------------------------------------------------
// pdsd_in_if
// Input channel: one segment, one query point and one radius per beat.
// ----------------------------------------------------------------------------
interface pdsd_in_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic        [COORD_BITS-2:0] stroke_radius;

  modport source (
    output valid, start_x, start_y, end_x, end_y, query_x, query_y, stroke_radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, query_x, query_y, stroke_radius,
    output ready
  );
endinterface

// File: hw/rtl/pdsd_out_if.sv
// ----------------------------------------------------------------------------
// pdsd_out_if
// Output channel: one distance and its path flag per beat.
// ----------------------------------------------------------------------------
interface pdsd_out_if #(
  parameter int COORD_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   distance;
  logic                  near_line;

  modport source (
    output valid, distance, near_line,
    input  ready
  );
  modport sink (
    input  valid, distance, near_line,
    output ready
  );
endinterface

// File: hw/rtl/pdsd_front.sv
// ----------------------------------------------------------------------------
// pdsd_front
// Three stages: differences and widened box, products and box test, sums of
// squares and absolute cross product.
// ----------------------------------------------------------------------------
module pdsd_front
  import pdsd_pkg::*;
#(
  parameter int CB = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [CB-1:0]   start_x_i,
  input  logic signed [CB-1:0]   start_y_i,
  input  logic signed [CB-1:0]   end_x_i,
  input  logic signed [CB-1:0]   end_y_i,
  input  logic signed [CB-1:0]   query_x_i,
  input  logic signed [CB-1:0]   query_y_i,
  input  logic        [CB-2:0]   stroke_radius_i,
  output logic                   valid_o,
  output logic [2*CB+2:0]        e0_o,
  output logic [2*CB+2:0]        e1_o,
  output logic [2*CB+2:0]        len2_o,
  output logic [2*CB+2:0]        cross_o,
  output logic                   near_o
);

  localparam int DW  = CB + 1;
  localparam int EW  = CB + 2;
  localparam int PW  = 2 * DW;
  localparam int SSW = PW + 1;

  // stage 1
  logic signed [DW-1:0] sx, sy, ex, ey, qx, qy;
  logic signed [CB-1:0] minx, maxx, miny, maxy;
  logic signed [DW-1:0] a0x_d, a0y_d, a1x_d, a1y_d, dx_d, dy_d;
  logic signed [DW-1:0] a0x_q, a0y_q, a1x_q, a1y_q, dx_q, dy_q;
  logic signed [EW-1:0] lox_d, hix_d, loy_d, hiy_d;
  logic signed [EW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic signed [CB-1:0] qx_q, qy_q;
  logic                 nz_d, nz1_q, v1_q;

  always_comb begin
    sx = $signed({start_x_i[CB-1], start_x_i});
    sy = $signed({start_y_i[CB-1], start_y_i});
    ex = $signed({end_x_i[CB-1], end_x_i});
    ey = $signed({end_y_i[CB-1], end_y_i});
    qx = $signed({query_x_i[CB-1], query_x_i});
    qy = $signed({query_y_i[CB-1], query_y_i});
    a0x_d = qx - sx;
    a0y_d = qy - sy;
    a1x_d = qx - ex;
    a1y_d = qy - ey;
    dx_d  = ex - sx;
    dy_d  = ey - sy;
    minx  = (start_x_i < end_x_i) ? start_x_i : end_x_i;
    maxx  = (start_x_i < end_x_i) ? end_x_i : start_x_i;
    miny  = (start_y_i < end_y_i) ? start_y_i : end_y_i;
    maxy  = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    lox_d = $signed({{2{minx[CB-1]}}, minx}) - $signed({3'b000, stroke_radius_i});
    hix_d = $signed({{2{maxx[CB-1]}}, maxx}) + $signed({3'b000, stroke_radius_i});
    loy_d = $signed({{2{miny[CB-1]}}, miny}) - $signed({3'b000, stroke_radius_i});
    hiy_d = $signed({{2{maxy[CB-1]}}, maxy}) + $signed({3'b000, stroke_radius_i});
    nz_d  = (start_x_i != end_x_i) || (start_y_i != end_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0x_q <= a0x_d;
      a0y_q <= a0y_d;
      a1x_q <= a1x_d;
      a1y_q <= a1y_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      lox_q <= lox_d;
      hix_q <= hix_d;
      loy_q <= loy_d;
      hiy_q <= hiy_d;
      qx_q  <= query_x_i;
      qy_q  <= query_y_i;
      nz1_q <= nz_d;
    end
  end

  // stage 2
  logic signed [PW-1:0] p0x_d, p0y_d, p1x_d, p1y_d, pdx_d, pdy_d, ca_d, cb_d;
  logic signed [PW-1:0] p0x_q, p0y_q, p1x_q, p1y_q, pdx_q, pdy_q, ca_q, cb_q;
  logic signed [EW-1:0] qxe, qye;
  logic                 in_d, in_q, nz2_q, v2_q;

  always_comb begin
    p0x_d = a0x_q * a0x_q;
    p0y_d = a0y_q * a0y_q;
    p1x_d = a1x_q * a1x_q;
    p1y_d = a1y_q * a1y_q;
    pdx_d = dx_q * dx_q;
    pdy_d = dy_q * dy_q;
    ca_d  = a1x_q * dy_q;
    cb_d  = a1y_q * dx_q;
    qxe   = $signed({{2{qx_q[CB-1]}}, qx_q});
    qye   = $signed({{2{qy_q[CB-1]}}, qy_q});
    in_d  = (qxe >= lox_q) && (qxe <= hix_q) && (qye >= loy_q) && (qye <= hiy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0x_q <= p0x_d;
      p0y_q <= p0y_d;
      p1x_q <= p1x_d;
      p1y_q <= p1y_d;
      pdx_q <= pdx_d;
      pdy_q <= pdy_d;
      ca_q  <= ca_d;
      cb_q  <= cb_d;
      in_q  <= in_d;
      nz2_q <= nz1_q;
    end
  end

  // stage 3
  logic signed [SSW-1:0] cdiff;
  logic [SSW-1:0]        e0_d, e1_d, l_d, c_d;
  logic [SSW-1:0]        e0_q, e1_q, l_q, c_q;
  logic                  near_q, v3_q;

  always_comb begin
    e0_d  = {1'b0, p0x_q} + {1'b0, p0y_q};
    e1_d  = {1'b0, p1x_q} + {1'b0, p1y_q};
    l_d   = {1'b0, pdx_q} + {1'b0, pdy_q};
    cdiff = $signed({ca_q[PW-1], ca_q}) - $signed({cb_q[PW-1], cb_q});
    c_d   = cdiff[SSW-1] ? $unsigned(-cdiff) : $unsigned(cdiff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q   <= e0_d;
      e1_q   <= e1_d;
      l_q    <= l_d;
      c_q    <= c_d;
      near_q <= in_q && nz2_q;
    end
  end

  assign valid_o = v3_q;
  assign e0_o    = e0_q;
  assign e1_o    = e1_q;
  assign len2_o  = l_q;
  assign cross_o = c_q;
  assign near_o  = near_q;

endmodule

// File: hw/rtl/pdsd_isqrt.sv
// ----------------------------------------------------------------------------
// pdsd_isqrt
// Pipelined integer square root, one root bit per stage, several radicands
// in lockstep with a sideband that travels along.
// ----------------------------------------------------------------------------
module pdsd_isqrt
  import pdsd_pkg::*;
#(
  parameter int RW  = 76,
  parameter int NUM = 3,
  parameter int SBW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW-1:0]     rad_i [NUM],
  input  logic [SBW-1:0]    sb_i,
  output logic              valid_o,
  output logic [RW/2-1:0]   root_o [NUM],
  output logic [SBW-1:0]    sb_o
);

  localparam int RTW = RW / 2;

  logic              vld_q  [RTW];
  logic [SBW-1:0]    sb_q   [RTW];
  logic [RW-1:0]     rad_q  [RTW][NUM];
  logic [RTW+1:0]    rem_q  [RTW][NUM];
  logic [RTW-1:0]    root_q [RTW][NUM];

  for (genvar s = 0; s < RTW; s++) begin : g_st
    logic           v_in;
    logic [SBW-1:0] sb_in;
    logic [RW-1:0]  rad_in  [NUM];
    logic [RTW+1:0] rem_in  [NUM];
    logic [RTW-1:0] root_in [NUM];
    logic [RW-1:0]  rad_d   [NUM];
    logic [RTW+1:0] rem_d   [NUM];
    logic [RTW-1:0] root_d  [NUM];

    if (s == 0) begin : g_first
      always_comb begin
        v_in  = valid_i;
        sb_in = sb_i;
        for (int n = 0; n < NUM; n++) begin
          rad_in[n]  = rad_i[n];
          rem_in[n]  = '0;
          root_in[n] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        v_in  = vld_q[s-1];
        sb_in = sb_q[s-1];
        for (int n = 0; n < NUM; n++) begin
          rad_in[n]  = rad_q[s-1][n];
          rem_in[n]  = rem_q[s-1][n];
          root_in[n] = root_q[s-1][n];
        end
      end
    end

    always_comb begin
      logic [RTW+1:0] cur;
      logic [RTW+1:0] trial;
      for (int n = 0; n < NUM; n++) begin
        cur      = {rem_in[n][RTW-1:0], rad_in[n][RW-1 -: 2]};
        trial    = {root_in[n], 2'b01};
        rad_d[n] = rad_in[n] << 2;
        if (cur >= trial) begin
          rem_d[n]  = cur - trial;
          root_d[n] = {root_in[n][RTW-2:0], 1'b1};
        end else begin
          rem_d[n]  = cur;
          root_d[n] = {root_in[n][RTW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[s] <= sb_in;
        for (int n = 0; n < NUM; n++) begin
          rad_q[s][n]  <= rad_d[n];
          rem_q[s][n]  <= rem_d[n];
          root_q[s][n] <= root_d[n];
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NUM; n++) begin
      root_o[n] = root_q[RTW-1][n];
    end
  end

  assign valid_o = vld_q[RTW-1];
  assign sb_o    = sb_q[RTW-1];

endmodule

// File: hw/rtl/pdsd_div.sv
// ----------------------------------------------------------------------------
// pdsd_div
// Pipelined restoring divider: an overflow check stage, then one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module pdsd_div
  import pdsd_pkg::*;
#(
  parameter int NW  = 59,
  parameter int DW  = 38,
  parameter int QW  = 21,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [QW-1:0]  quot_o,
  output logic           sat_o,
  output logic [SBW-1:0] sb_o
);

  localparam int RMW = DW + QW;
  localparam int CW  = (NW > RMW) ? NW : RMW;
  localparam int NS  = QW + 1;

  logic           vld_q [NS];
  logic [SBW-1:0] sb_q  [NS];
  logic [RMW-1:0] rem_q [NS];
  logic [DW-1:0]  den_q [NS];
  logic [QW-1:0]  quo_q [NS];
  logic           sat_q [NS];

  // overflow check
  logic [CW-1:0] num_ext, big_ext;

  always_comb begin
    num_ext = CW'(num_i);
    big_ext = CW'({den_i, {QW{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0]  <= sb_i;
      rem_q[0] <= num_ext[RMW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= num_ext >= big_ext;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_st
    logic [RMW-1:0] trial;
    logic           take;

    always_comb begin
      trial = {den_q[s-1], {QW{1'b0}}} >> s;
      take  = rem_q[s-1] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[s]  <= sb_q[s-1];
        den_q[s] <= den_q[s-1];
        sat_q[s] <= sat_q[s-1];
        rem_q[s] <= take ? (rem_q[s-1] - trial) : rem_q[s-1];
        quo_q[s] <= {quo_q[s-1][QW-2:0], take};
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign sat_o   = sat_q[NS-1];
  assign sb_o    = sb_q[NS-1];

endmodule

// File: hw/rtl/point_to_stroke_distance_unit.sv
// ----------------------------------------------------------------------------
// point_to_stroke_distance_unit
// Distance from a query point to a stroke segment: perpendicular line
// distance inside the radius-widened box, else nearest end-point distance.
//
// channel  dir  handshake     payload
// in_i     in   valid/ready   start, end, query coordinates, stroke_radius
// out_o    out  valid/ready   distance, near_line
//
// one item enters per cycle unless the output beat waits; it passes the front
// stages, bit-per-stage root, end-point register, divider and output register
// reset clears every valid bit, payload registers are not reset
// the whole pipeline holds while the output beat waits, nothing is dropped
// ----------------------------------------------------------------------------
module point_to_stroke_distance_unit
  import pdsd_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdsd_in_if.sink    in_i,
  pdsd_out_if.source out_o
);

  localparam int CB   = COORD_BITS;
  localparam int SSW  = 2 * (CB + 1) + 1;
  localparam int RADW = SSW + 2 * LEN_EXTRA;
  localparam int RW   = RADW + (RADW % 2);
  localparam int RTW  = RW / 2;
  localparam int OB   = CB + 1;
  localparam int NW   = SSW + LEN_EXTRA;
  localparam int SBW  = SSW + 1;

  logic en;
  logic out_valid_q;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // front stages
  logic           f_valid, f_near;
  logic [SSW-1:0] f_e0, f_e1, f_len2, f_cross;

  pdsd_front #(.CB(CB)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_i.valid),
    .start_x_i      (in_i.start_x),
    .start_y_i      (in_i.start_y),
    .end_x_i        (in_i.end_x),
    .end_y_i        (in_i.end_y),
    .query_x_i      (in_i.query_x),
    .query_y_i      (in_i.query_y),
    .stroke_radius_i(in_i.stroke_radius),
    .valid_o        (f_valid),
    .e0_o           (f_e0),
    .e1_o           (f_e1),
    .len2_o         (f_len2),
    .cross_o        (f_cross),
    .near_o         (f_near)
  );

  // roots
  logic [RW-1:0]  rad [3];
  logic [RTW-1:0] root [3];
  logic           r_valid;
  logic [SBW-1:0] r_sb;

  always_comb begin
    rad[0] = RW'(f_e0);
    rad[1] = RW'(f_e1);
    rad[2] = RW'({f_len2, {(2 * LEN_EXTRA){1'b0}}});
  end

  pdsd_isqrt #(.RW(RW), .NUM(3), .SBW(SBW)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(f_valid),
    .rad_i  (rad),
    .sb_i   ({f_cross, f_near}),
    .valid_o(r_valid),
    .root_o (root),
    .sb_o   (r_sb)
  );

  // nearest end point
  logic [RTW-1:0] emin;
  logic [OB-1:0]  edist_d, edist_q;
  logic [NW-1:0]  num_q;
  logic [RTW-1:0] den_q;
  logic           pnear_q, pvalid_q;

  always_comb begin
    emin    = (root[0] < root[1]) ? root[0] : root[1];
    edist_d = (emin > RTW'({OB{1'b1}})) ? {OB{1'b1}} : emin[OB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (en) begin
      pvalid_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      edist_q <= edist_d;
      num_q   <= {r_sb[SBW-1:1], {LEN_EXTRA{1'b0}}};
      den_q   <= root[2];
      pnear_q <= r_sb[0];
    end
  end

  // line distance
  logic          d_valid, d_sat, d_near;
  logic [OB-1:0] d_quot, d_edist;

  pdsd_div #(.NW(NW), .DW(RTW), .QW(OB), .SBW(OB + 1)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pvalid_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .sb_i   ({pnear_q, edist_q}),
    .valid_o(d_valid),
    .quot_o (d_quot),
    .sat_o  (d_sat),
    .sb_o   ({d_near, d_edist})
  );

  // output register
  logic [OB-1:0] dist_d, dist_q;
  logic          near_q;

  always_comb begin
    if (d_near) begin
      dist_d = d_sat ? {OB{1'b1}} : d_quot;
    end else begin
      dist_d = d_edist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
      near_q <= d_near;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.distance  = dist_q;
  assign out_o.near_line = near_q;

`ifndef SYNTH
  a_zero_len_not_near : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && (f_len2 == '0)) |-> !f_near)
    else $error("zero-length segment took the line path");

  a_stall_holds_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(d_valid) && $stable(d_quot)))
    else $error("divider moved during an output stall");

  a_accept_only_when_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_valid_q || out_o.ready))
    else $error("input beat taken while the pipeline was held");
`endif

endmodule
